// ===== rtl/can_signal_mapping_translator_defines.svh =====
// Assertion macros shared by the translator RTL.
`ifndef CAN_SIGNAL_MAPPING_TRANSLATOR_DEFINES_SVH
`define CAN_SIGNAL_MAPPING_TRANSLATOR_DEFINES_SVH
// Same-cycle implication, checked on every clock edge outside reset.
`define CSMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define CSMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/csmt_pkg.sv =====
// Types and constants shared by the CAN signal mapping translator.
package csmt_pkg;

  localparam logic [2:0] CMD_MSG  = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_REM  = 3'd2;
  localparam logic [2:0] CMD_EN   = 3'd3;
  localparam logic [2:0] CMD_CLR  = 3'd4;
  localparam logic [2:0] CMD_STAT = 3'd5;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_UNKNOWN  = 4'd1;
  localparam logic [3:0] ST_DISABLED = 4'd2;
  localparam logic [3:0] ST_EXTRACT  = 4'd3;
  localparam logic [3:0] ST_RANGE    = 4'd4;
  localparam logic [3:0] ST_FULL     = 4'd5;
  localparam logic [3:0] ST_INVALID  = 4'd6;
  localparam logic [3:0] ST_DUP      = 4'd7;
  localparam logic [3:0] ST_BADIDX   = 4'd8;

  localparam logic [2:0] MAX_START = 3'd7;

  typedef enum logic [2:0] {
    OP_MSG, OP_ADD, OP_REM, OP_EN, OP_CLR, OP_STAT, OP_BAD
  } op_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [28:0]        can_id;
    logic [63:0]        payload;
    logic [3:0]         frame_length;
    logic [31:0]        msg_id;
    logic [2:0]         first_byte;
    logic [2:0]         layout;
    logic signed [31:0] scale;
    logic signed [31:0] lower_limit;
    logic signed [31:0] upper_limit;
    logic [5:0]         entry_index;
    logic               enable_flag;
  } item_t;

  typedef struct packed {
    op_e   op;
    logic  add_bad;
    item_t item;
  } work_t;

  typedef struct packed {
    logic [28:0] key;
    logic [31:0] target;
    logic        en;
    logic [2:0]  start;
    logic [2:0]  lay;
    logic [31:0] scale;
    logic [31:0] lo;
    logic [31:0] hi;
  } entry_t;

  typedef struct packed {
    logic [3:0]         status;
    logic               publish;
    logic [31:0]        out_msg_id;
    logic signed [47:0] out_value;
    logic [6:0]         mappings_in_use;
    logic [31:0]        processed_count;
    logic [31:0]        translated_count;
    logic [31:0]        unknown_count;
    logic [31:0]        extract_error_count;
    logic [31:0]        range_error_count;
  } res_t;

endpackage

// ===== rtl/csmt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module csmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/csmt_front.sv =====
// Input queue that takes items and classifies their command.
module csmt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  csmt_pkg::item_t  item_i,
  output logic             work_valid_o,
  output csmt_pkg::work_t  work_o,
  input  logic             work_take_i
);
  import csmt_pkg::*;

  work_t       slot_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  work_t       cls;
  logic        acc, take;

  always_comb begin
    cls.item = item_i;
    case (item_i.cmd)
      CMD_MSG:  cls.op = OP_MSG;
      CMD_ADD:  cls.op = OP_ADD;
      CMD_REM:  cls.op = OP_REM;
      CMD_EN:   cls.op = OP_EN;
      CMD_CLR:  cls.op = OP_CLR;
      CMD_STAT: cls.op = OP_STAT;
      default:  cls.op = OP_BAD;
    endcase
    // Table-independent add checks; a two-byte field may not start at the last byte.
    cls.add_bad = (item_i.can_id == '0) || (item_i.msg_id == '0) ||
                  (item_i.layout[0] && (item_i.first_byte == MAX_START)) ||
                  (item_i.scale == '0) || (item_i.lower_limit > item_i.upper_limit);
  end

  assign full_o       = (cnt_q == 2'd2);
  assign acc          = push_i && !full_o;
  assign work_valid_o = (cnt_q != 2'd0);
  assign take         = work_take_i && work_valid_o;
  assign work_o       = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (acc) begin
      slot_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (acc) wptr_q <= ~wptr_q;
      if (take) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, take};
    end
  end

`include "can_signal_mapping_translator_defines.svh"
  `CSMT_ASSERT_IMP(a_front_bound, 1'b1, cnt_q <= 2'd2, "front queue count out of range")
  `CSMT_ASSERT_NXT(a_front_keep, work_valid_o && !work_take_i, work_valid_o && $stable(work_o), "waiting item changed")
  `CSMT_ASSERT_NXT(a_front_fill, acc && !take && (cnt_q == 2'd1), full_o, "front queue not full")
endmodule

// ===== rtl/csmt_back.sv =====
// Table lookup, maintenance and scaling sequencer with the result register.
module csmt_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             work_valid_i,
  input  csmt_pkg::work_t  work_i,
  output logic             work_take_o,
  output logic             res_valid_o,
  output csmt_pkg::res_t   res_o,
  input  logic             res_pop_i
);
  import csmt_pkg::*;

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EW = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_MUL, S_CHECK,
    S_RM_RD, S_RM_WR, S_EN_RD, S_EN_WR, S_DONE
  } state_e;

  state_e              state_q;
  work_t               work_q;
  entry_t              ent_q;
  logic [CW-1:0]       count_q, ptr_q;
  logic [31:0]         proc_q, trans_q, unk_q, ext_q, rng_q;
  logic [3:0]          st_q;
  logic                pub_q;
  logic [31:0]         tgt_q;
  logic signed [47:0]  val_q;
  logic signed [48:0]  prod_q;
  logic                res_valid_q;
  res_t                res_q;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;
  logic [EW-1:0]       rdata_raw;
  entry_t              new_ent;
  logic [CW:0]         ptr_next;
  logic                idx_bad, out_free;
  logic [7:0]          b0, b1;
  logic [15:0]         word;
  logic signed [16:0]  raw;
  logic [3:0]          need;
  logic signed [48:0]  lo_ext, hi_ext;

  csmt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata_raw)
  );
  assign ram_rdata = entry_t'(rdata_raw);

  assign ptr_next    = {1'b0, ptr_q} + {{CW{1'b0}}, 1'b1};
  assign idx_bad     = {1'b0, work_i.item.entry_index} >= 7'(count_q);
  assign out_free    = !res_valid_q || res_pop_i;
  assign work_take_o = (state_q == S_IDLE) && work_valid_i && out_free;

  always_comb begin
    new_ent.key    = work_q.item.can_id;
    new_ent.target = work_q.item.msg_id;
    new_ent.en     = work_q.item.enable_flag;
    new_ent.start  = work_q.item.first_byte;
    new_ent.lay    = work_q.item.layout;
    new_ent.scale  = work_q.item.scale;
    new_ent.lo     = work_q.item.lower_limit;
    new_ent.hi     = work_q.item.upper_limit;

    ram_we    = 1'b0;
    ram_waddr = ptr_q[IW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr_q[IW-1:0];
    case (state_q)
      S_SCAN_RD: begin
        if ((ptr_q == count_q) && (work_q.op == OP_ADD)) begin
          ram_we    = 1'b1;
          ram_waddr = count_q[IW-1:0];
          ram_wdata = new_ent;
        end
      end
      S_RM_RD:  ram_raddr = ptr_next[IW-1:0];
      S_RM_WR:  ram_we = 1'b1;
      S_EN_RD:  ram_raddr = work_q.item.entry_index[IW-1:0];
      S_EN_WR: begin
        ram_we       = 1'b1;
        ram_waddr    = work_q.item.entry_index[IW-1:0];
        ram_wdata.en = work_q.item.enable_flag;
      end
      default: ;
    endcase
  end

  // Field extraction from the matched entry; the second byte wraps within the payload.
  always_comb begin
    b0   = work_q.item.payload[{ent_q.start, 3'b000} +: 8];
    b1   = work_q.item.payload[{ent_q.start + 3'd1, 3'b000} +: 8];
    word = ent_q.lay[1] ? {b0, b1} : {b1, b0};
    if (ent_q.lay[0]) begin
      raw = {ent_q.lay[2] & word[15], word};
    end else begin
      raw = {{9{ent_q.lay[2] & b0[7]}}, b0};
    end
    need   = {1'b0, ram_rdata.start} + (ram_rdata.lay[0] ? 4'd2 : 4'd1);
    lo_ext = {{17{ent_q.lo[31]}}, ent_q.lo};
    hi_ext = {{17{ent_q.hi[31]}}, ent_q.hi};
  end

  always_ff @(posedge clk_i) begin
    if (work_take_o) work_q <= work_i;
    if (state_q == S_MUL) prod_q <= raw * $signed(ent_q.scale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      proc_q      <= '0;
      trans_q     <= '0;
      unk_q       <= '0;
      ext_q       <= '0;
      rng_q       <= '0;
      st_q        <= ST_OK;
      pub_q       <= 1'b0;
      tgt_q       <= '0;
      val_q       <= '0;
      ent_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_pop_i && res_valid_q) res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (work_take_o) begin
            pub_q   <= 1'b0;
            tgt_q   <= '0;
            val_q   <= '0;
            st_q    <= ST_OK;
            ptr_q   <= '0;
            state_q <= S_DONE;
            case (work_i.op)
              OP_MSG: begin
                proc_q  <= proc_q + 32'd1;
                state_q <= S_SCAN_RD;
              end
              OP_ADD: begin
                if (count_q >= CW'(TABLE_ENTRIES)) st_q <= ST_FULL;
                else if (work_i.add_bad) st_q <= ST_INVALID;
                else state_q <= S_SCAN_RD;
              end
              OP_REM: begin
                if (idx_bad) st_q <= ST_BADIDX;
                else begin
                  ptr_q   <= CW'(work_i.item.entry_index);
                  state_q <= S_RM_RD;
                end
              end
              OP_EN: begin
                if (idx_bad) st_q <= ST_BADIDX;
                else state_q <= S_EN_RD;
              end
              OP_CLR: count_q <= '0;
              OP_STAT: begin
                proc_q  <= '0;
                trans_q <= '0;
                unk_q   <= '0;
                ext_q   <= '0;
                rng_q   <= '0;
              end
              default: st_q <= ST_INVALID;
            endcase
          end
        end
        S_SCAN_RD: begin
          if (ptr_q == count_q) begin
            state_q <= S_DONE;
            if (work_q.op == OP_ADD) begin
              count_q <= count_q + CW'(1);
            end else begin
              unk_q <= unk_q + 32'd1;
              st_q  <= ST_UNKNOWN;
            end
          end else begin
            state_q <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (ram_rdata.key == work_q.item.can_id) begin
            ent_q   <= ram_rdata;
            state_q <= S_DONE;
            if (work_q.op == OP_ADD) st_q <= ST_DUP;
            else if (!ram_rdata.en) st_q <= ST_DISABLED;
            else if (need > work_q.item.frame_length) begin
              st_q  <= ST_EXTRACT;
              ext_q <= ext_q + 32'd1;
            end else state_q <= S_MUL;
          end else begin
            ptr_q   <= ptr_next[CW-1:0];
            state_q <= S_SCAN_RD;
          end
        end
        S_MUL: state_q <= S_CHECK;
        S_CHECK: begin
          state_q <= S_DONE;
          if ((prod_q < lo_ext) || (prod_q > hi_ext)) begin
            st_q  <= ST_RANGE;
            rng_q <= rng_q + 32'd1;
          end else begin
            trans_q <= trans_q + 32'd1;
            pub_q   <= 1'b1;
            tgt_q   <= ent_q.target;
            val_q   <= prod_q[47:0];
          end
        end
        S_RM_RD: begin
          if (ptr_next >= {1'b0, count_q}) begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          ptr_q   <= ptr_next[CW-1:0];
          state_q <= S_RM_RD;
        end
        S_EN_RD: state_q <= S_EN_WR;
        S_EN_WR: state_q <= S_DONE;
        S_DONE: begin
          res_q.status              <= st_q;
          res_q.publish             <= pub_q;
          res_q.out_msg_id          <= tgt_q;
          res_q.out_value           <= val_q;
          res_q.mappings_in_use     <= 7'(count_q);
          res_q.processed_count     <= proc_q;
          res_q.translated_count    <= trans_q;
          res_q.unknown_count       <= unk_q;
          res_q.extract_error_count <= ext_q;
          res_q.range_error_count   <= rng_q;
          res_valid_q               <= 1'b1;
          state_q                   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`include "can_signal_mapping_translator_defines.svh"
  `CSMT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(TABLE_ENTRIES), "table count overflow")
  `CSMT_ASSERT_IMP(a_pub_ok, res_valid_q && res_q.publish, res_q.status == ST_OK, "publish without ok")
  `CSMT_ASSERT_NXT(a_res_hold, res_valid_q && !res_pop_i, res_valid_q && $stable(res_q), "result lost")
  `CSMT_ASSERT_IMP(a_done_free, state_q == S_DONE, !res_valid_q, "result overwritten")
endmodule

// ===== rtl/can_signal_mapping_translator.sv =====
// Top level of the CAN signal mapping translator: input queue, sequencer and result register.
// Clear, statistics reset and rejected commands go straight to the result; set enable
// reads and rewrites one entry; a message or add reads and compares the entries in turn,
// and a matched, enabled message that fits its frame is scaled and range-checked; a remove
// shifts the later entries down. Items are run one at a time; a waiting result stalls them.
// Asynchronous active-low reset empties the queues and zeroes the count and the five counters.
module can_signal_mapping_translator #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         cmd_i,
  input  logic [28:0]        can_id_i,
  input  logic [63:0]        payload_i,
  input  logic [3:0]         frame_length_i,
  input  logic [31:0]        msg_id_i,
  input  logic [2:0]         first_byte_i,
  input  logic [2:0]         layout_i,
  input  logic signed [31:0] scale_i,
  input  logic signed [31:0] lower_limit_i,
  input  logic signed [31:0] upper_limit_i,
  input  logic [5:0]         entry_index_i,
  input  logic               enable_flag_i,
  output logic               empty,
  input  logic               pop,
  output logic [3:0]         status_o,
  output logic               publish_o,
  output logic [31:0]        out_msg_id_o,
  output logic signed [47:0] out_value_o,
  output logic [6:0]         mappings_in_use_o,
  output logic [31:0]        processed_count_o,
  output logic [31:0]        translated_count_o,
  output logic [31:0]        unknown_count_o,
  output logic [31:0]        extract_error_count_o,
  output logic [31:0]        range_error_count_o
);
  import csmt_pkg::*;

  item_t item;
  work_t work;
  logic  work_valid, work_take, res_valid;
  res_t  res;

  // Gather the input fields into one item for the front queue.
  always_comb begin
    item.cmd          = cmd_i;
    item.can_id       = can_id_i;
    item.payload      = payload_i;
    item.frame_length = frame_length_i;
    item.msg_id       = msg_id_i;
    item.first_byte   = first_byte_i;
    item.layout       = layout_i;
    item.scale        = scale_i;
    item.lower_limit  = lower_limit_i;
    item.upper_limit  = upper_limit_i;
    item.entry_index  = entry_index_i;
    item.enable_flag  = enable_flag_i;
  end

  // The front queue accepts items while the sequencer works or a result waits, until both its slots are full.
  csmt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .item_i       (item),
    .work_valid_o (work_valid),
    .work_o       (work),
    .work_take_i  (work_take)
  );

  // The sequencer runs one item at a time and holds its result until it is popped.
  csmt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_i       (work),
    .work_take_o  (work_take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty                 = !res_valid;
  assign status_o              = res.status;
  assign publish_o             = res.publish;
  assign out_msg_id_o          = res.out_msg_id;
  assign out_value_o           = res.out_value;
  assign mappings_in_use_o     = res.mappings_in_use;
  assign processed_count_o     = res.processed_count;
  assign translated_count_o    = res.translated_count;
  assign unknown_count_o       = res.unknown_count;
  assign extract_error_count_o = res.extract_error_count;
  assign range_error_count_o   = res.range_error_count;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the CAN signal mapping translator.
module tb;
  import csmt_pkg::*;

  localparam int ENTRIES = 16;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Block ports.
  logic               push = 1'b0;
  logic               full;
  logic [2:0]         cmd_i = '0;
  logic [28:0]        can_id_i = '0;
  logic [63:0]        payload_i = '0;
  logic [3:0]         frame_length_i = '0;
  logic [31:0]        msg_id_i = '0;
  logic [2:0]         first_byte_i = '0;
  logic [2:0]         layout_i = '0;
  logic signed [31:0] scale_i = '0;
  logic signed [31:0] lower_limit_i = '0;
  logic signed [31:0] upper_limit_i = '0;
  logic [5:0]         entry_index_i = '0;
  logic               enable_flag_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [3:0]         status_o;
  logic               publish_o;
  logic [31:0]        out_msg_id_o;
  logic signed [47:0] out_value_o;
  logic [6:0]         mappings_in_use_o;
  logic [31:0]        processed_count_o;
  logic [31:0]        translated_count_o;
  logic [31:0]        unknown_count_o;
  logic [31:0]        extract_error_count_o;
  logic [31:0]        range_error_count_o;

  can_signal_mapping_translator #(.TABLE_ENTRIES(ENTRIES)) u_dut (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .can_id_i, .payload_i, .frame_length_i,
    .msg_id_i, .first_byte_i, .layout_i, .scale_i, .lower_limit_i, .upper_limit_i,
    .entry_index_i, .enable_flag_i, .empty, .pop, .status_o, .publish_o,
    .out_msg_id_o, .out_value_o, .mappings_in_use_o, .processed_count_o,
    .translated_count_o, .unknown_count_o, .extract_error_count_o,
    .range_error_count_o
  );

  // The predictor's model of the translator's mapping table and counters. An
  // entry is only ever read below the mapping count.
  entry_t      map_tab [ENTRIES];
  int unsigned map_count = 0;
  logic [31:0] n_processed = '0;
  logic [31:0] n_translated = '0;
  logic [31:0] n_unknown = '0;
  logic [31:0] n_extract = '0;
  logic [31:0] n_range = '0;

  res_t expected_results[$];
  int   error_count = 0;

  // Idling control: percentages that the stimulus process changes by phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_receiver = 1'b0;
  int unsigned hold_cycles = 0;

  function automatic int find_mapping(logic [28:0] key);
    for (int i = 0; i < map_count; i++)
      if (map_tab[i].key == key) return i;
    return -1;
  endfunction

  function automatic logic signed [63:0] sx32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Works out the result of one item and updates the predicted state.
  function automatic res_t translate_item(item_t it);
    res_t r;
    int   idx;
    logic [7:0] b0, b1;
    logic signed [63:0] raw, prod;
    int unsigned len;
    r = '0;
    case (it.cmd)
      CMD_MSG: begin
        n_processed++;
        idx = find_mapping(it.can_id);
        if (idx < 0) begin
          n_unknown++;
          r.status = ST_UNKNOWN;
        end else if (!map_tab[idx].en) begin
          r.status = ST_DISABLED;
        end else begin
          len = map_tab[idx].lay[0] ? 2 : 1;
          if (map_tab[idx].start + len > it.frame_length) begin
            n_extract++;
            r.status = ST_EXTRACT;
          end else begin
            b0 = it.payload[8*map_tab[idx].start +: 8];
            if (len == 1) begin
              raw = {56'd0, b0};
              if (map_tab[idx].lay[2] && b0[7]) raw -= 64'sd256;
            end else begin
              b1 = it.payload[8*(map_tab[idx].start + 1) +: 8];
              raw = map_tab[idx].lay[1] ? {48'd0, b0, b1} : {48'd0, b1, b0};
              if (map_tab[idx].lay[2] && raw >= 64'sh8000) raw -= 64'sh10000;
            end
            prod = raw * sx32(map_tab[idx].scale);
            if (prod < sx32(map_tab[idx].lo) || prod > sx32(map_tab[idx].hi)) begin
              n_range++;
              r.status = ST_RANGE;
            end else begin
              n_translated++;
              r.status = ST_OK;
              r.publish = 1'b1;
              r.out_msg_id = map_tab[idx].target;
              r.out_value = prod[47:0];
            end
          end
        end
      end
      CMD_ADD: begin
        if (map_count >= ENTRIES) r.status = ST_FULL;
        else if (it.can_id == 0 || it.msg_id == 0 || (it.layout[0] && it.first_byte == MAX_START)
                 || it.scale == 0 || it.lower_limit > it.upper_limit) r.status = ST_INVALID;
        else if (find_mapping(it.can_id) >= 0) r.status = ST_DUP;
        else begin
          map_tab[map_count] = '{key: it.can_id, target: it.msg_id, en: it.enable_flag,
                                 start: it.first_byte, lay: it.layout, scale: it.scale,
                                 lo: it.lower_limit, hi: it.upper_limit};
          map_count++;
          r.status = ST_OK;
        end
      end
      CMD_REM: begin
        if (it.entry_index >= map_count) r.status = ST_BADIDX;
        else begin
          for (int i = it.entry_index; i + 1 < map_count; i++) map_tab[i] = map_tab[i + 1];
          map_count--;
          r.status = ST_OK;
        end
      end
      CMD_EN: begin
        if (it.entry_index >= map_count) r.status = ST_BADIDX;
        else begin
          map_tab[it.entry_index].en = it.enable_flag;
          r.status = ST_OK;
        end
      end
      CMD_CLR: begin
        map_count = 0;
        r.status = ST_OK;
      end
      CMD_STAT: begin
        {n_processed, n_translated, n_unknown, n_extract, n_range} = '0;
        r.status = ST_OK;
      end
      default: r.status = ST_INVALID;
    endcase
    r.mappings_in_use = map_count[6:0];
    r.processed_count = n_processed;
    r.translated_count = n_translated;
    r.unknown_count = n_unknown;
    r.extract_error_count = n_extract;
    r.range_error_count = n_range;
    return r;
  endfunction

  // Offers one item and waits until the block takes it. Predicted results are
  // queued at the accepting edge, so they always precede the block's answer.
  // Push stays high after acceptance; the caller lowers it before any pause.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    {cmd_i, can_id_i, payload_i, frame_length_i, msg_id_i, first_byte_i, layout_i,
     scale_i, lower_limit_i, upper_limit_i, entry_index_i, enable_flag_i} <= it;
    do @(posedge clk_i); while (full);
    expected_results.push_back(translate_item(it));
  endtask

  // Directed rows: an item and, where it is obvious, its expected status.
  typedef struct {
    item_t      it;
    bit         has_status;
    logic [3:0] status;
  } row_t;

  function automatic item_t mk_item(logic [2:0] c, logic [28:0] id, logic [63:0] pl,
                                    logic [3:0] fl, logic [31:0] tgt, logic [2:0] bs,
                                    logic [2:0] lay, logic [31:0] sc, logic [31:0] lo,
                                    logic [31:0] hi, logic [5:0] ix, logic en);
    return '{c, id, pl, fl, tgt, bs, lay, sc, lo, hi, ix, en};
  endfunction

  // Random content: keys from a small pool so messages hit the table often.
  function automatic logic [28:0] pick_key();
    case ($urandom_range(9))
      0: return 29'h1FFF_FFFF;
      1: return 29'($urandom());
      default: return 29'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< $urandom_range(0, 16);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    logic [31:0] a, b;
    logic [287:0] bits_v;
    bits_v = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom()};
    it = bits_v[$bits(item_t)-1:0];
    it.can_id = pick_key();
    it.frame_length = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
    case ($urandom_range(99)) inside
      [0:44]:  it.cmd = CMD_MSG;
      [45:69]: begin
        it.cmd = CMD_ADD;
        a = pick_q16();
        b = pick_q16();
        if ($urandom_range(9) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
        it.lower_limit = a;
        it.upper_limit = b;
        it.scale = ($urandom_range(19) == 0) ? 32'd0 : pick_q16();
        if ($urandom_range(19) == 0) it.msg_id = '0;
        if ($urandom_range(3) != 0) it.enable_flag = 1'b1;
      end
      [70:79]: it.cmd = CMD_REM;
      [80:91]: it.cmd = CMD_EN;
      [92:94]: it.cmd = CMD_CLR;
      [95:97]: it.cmd = CMD_STAT;
      default: it.cmd = 3'($urandom_range(OP_BAD, 7));
    endcase
    if (it.cmd == CMD_REM || it.cmd == CMD_EN)
      it.entry_index = ($urandom_range(7) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 17));
    return it;
  endfunction

  // Result side: pops at random and checks every field against the oldest
  // expectation.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d", $time, status_o);
        error_count++;
      end else begin
        res_t e, a;
        e = expected_results.pop_front();
        a = '{status_o, publish_o, out_msg_id_o, out_value_o, mappings_in_use_o,
              processed_count_o, translated_count_o, unknown_count_o,
              extract_error_count_o, range_error_count_o};
        if (a.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
        if (a.publish !== e.publish)
          $display("%0t: publish exp %0d got %0d", $time, e.publish, a.publish);
        if (a.out_msg_id !== e.out_msg_id)
          $display("%0t: out_msg_id exp %h got %h", $time, e.out_msg_id, a.out_msg_id);
        if (a.out_value !== e.out_value)
          $display("%0t: out_value exp %h got %h", $time, e.out_value, a.out_value);
        if (a.mappings_in_use !== e.mappings_in_use)
          $display("%0t: mappings exp %0d got %0d", $time, e.mappings_in_use,
                   a.mappings_in_use);
        if (a.processed_count !== e.processed_count)
          $display("%0t: processed exp %0d got %0d", $time, e.processed_count,
                   a.processed_count);
        if (a.translated_count !== e.translated_count)
          $display("%0t: translated exp %0d got %0d", $time, e.translated_count,
                   a.translated_count);
        if (a.unknown_count !== e.unknown_count)
          $display("%0t: unknown exp %0d got %0d", $time, e.unknown_count, a.unknown_count);
        if (a.extract_error_count !== e.extract_error_count)
          $display("%0t: extract exp %0d got %0d", $time, e.extract_error_count,
                   a.extract_error_count);
        if (a.range_error_count !== e.range_error_count)
          $display("%0t: range exp %0d got %0d", $time, e.range_error_count,
                   a.range_error_count);
        if (a !== e) error_count++;
      end
    end
  end

  // The pop decision for the next edge is made here, once per edge. A long
  // hold-off is counted down in this process alone.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else if (hold_receiver) begin
      hold_cycles <= 400;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Main stimulus.
  initial begin
    row_t        rows[$];
    res_t        first;
    int unsigned wait_cycles;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Statuses given only where plain from the command and the table so far.
    rows.push_back('{mk_item(CMD_MSG, 29'd5, '0, 4'd8, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_UNKNOWN});
    rows.push_back('{mk_item(CMD_REM, 0, '0, 0, 0, 0, 0, 0, 0, 0, 6'd0, 0), 1, ST_BADIDX});
    rows.push_back('{mk_item(CMD_EN, 0, '0, 0, 0, 0, 0, 0, 0, 0, 6'd63, 1), 1, ST_BADIDX});
    rows.push_back('{mk_item(3'd6, 0, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_INVALID});
    rows.push_back('{mk_item(3'd7, 0, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_INVALID});
    // Add rejections: zero key, zero target, two bytes at the last offset,
    // zero scale, inverted limits.
    rows.push_back('{mk_item(CMD_ADD, 0, '0, 0, 1, 0, 0, 1, 0, 1, 0, 1), 1, ST_INVALID});
    rows.push_back('{mk_item(CMD_ADD, 1, '0, 0, 0, 0, 0, 1, 0, 1, 0, 1), 1, ST_INVALID});
    rows.push_back('{mk_item(CMD_ADD, 1, '0, 0, 1, 7, 1, 1, 0, 1, 0, 1), 1, ST_INVALID});
    rows.push_back('{mk_item(CMD_ADD, 1, '0, 0, 1, 0, 0, 0, 0, 1, 0, 1), 1, ST_INVALID});
    rows.push_back('{mk_item(CMD_ADD, 1, '0, 0, 1, 0, 0, 1, 5, 4, 0, 1), 1, ST_INVALID});
    // Good adds at the extremes.
    rows.push_back('{mk_item(CMD_ADD, 29'h1FFF_FFFF, '0, 0, 32'hFFFF_FFFF, 3'd6, 3'd7,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1), 1, ST_OK});
    rows.push_back('{mk_item(CMD_ADD, 29'd2, '0, 0, 32'd9, 3'd7, 3'd4, 32'h8000_0000,
                             32'h8000_0000, 32'h7FFF_FFFF, 0, 1), 1, ST_OK});
    rows.push_back('{mk_item(CMD_ADD, 29'd3, '0, 0, 32'd3, 3'd0, 3'd1, 32'h0001_0000,
                             32'h0000_0000, 32'h0010_0000, 0, 0), 1, ST_OK});
    rows.push_back('{mk_item(CMD_ADD, 29'd2, '0, 0, 32'd4, 0, 0, 1, 0, 1, 0, 1), 1, ST_DUP});
    // Messages: extremes of payload, short frame, disabled, range.
    rows.push_back('{mk_item(CMD_MSG, 29'h1FFF_FFFF, 64'h80FF_FFFF_FFFF_FFFF, 4'd8,
                             0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk_item(CMD_MSG, 29'd2, 64'h8000_0000_0000_0000, 4'd15,
                             0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk_item(CMD_MSG, 29'd2, '1, 4'd7, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk_item(CMD_MSG, 29'd3, '1, 4'd8, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_DISABLED});
    rows.push_back('{mk_item(CMD_EN, 0, '0, 0, 0, 0, 0, 0, 0, 0, 6'd2, 1), 1, ST_OK});
    rows.push_back('{mk_item(CMD_MSG, 29'd3, 64'h0000_0000_0000_00FF, 4'd2,
                             0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk_item(CMD_MSG, 29'd3, 64'h0000_0000_0000_FFFF, 4'd2,
                             0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
    rows.push_back('{mk_item(CMD_REM, 0, '0, 0, 0, 0, 0, 0, 0, 0, 6'd0, 0), 1, ST_OK});
    rows.push_back('{mk_item(CMD_STAT, 0, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK});
    rows.push_back('{mk_item(CMD_CLR, 0, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ST_OK});

    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].has_status) begin
        first = expected_results[$];
        if (first.status !== rows[i].status) begin
          $display("%0t: row %0d status exp %0d, predictor %0d", $time, i,
                   rows[i].status, first.status);
          error_count++;
        end
      end
    end

    // Fill the table completely so that the full case is reached.
    for (int k = 0; k <= ENTRIES; k++)
      send_item(mk_item(CMD_ADD, 29'(k + 100), '0, 0, 32'(k + 1), 3'(k % 7), 3'(k % 8),
                        32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1));
    send_item(mk_item(CMD_CLR, 0, '0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // Random part in idling phases.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        3: begin send_idle_pct = 30; recv_stall_pct = 30; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // A long receiver hold-off while items keep coming fills the block.
      if (ph == 4) begin
        hold_receiver = 1'b1;
        repeat (2) @(posedge clk_i);
        hold_receiver = 1'b0;
      end
      for (int n = 0; n < 250; n++) send_item(random_item());
      // The sender pauses until every expected result has come.
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clk_i);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Overall limit.
  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

endmodule
